FILE: design/ffta_pkg.sv
// Shared constants and types for the first-fit timed allocator.
package ffta_pkg;

    localparam int FREE_SLOTS   = 64;
    localparam int ACTIVE_SLOTS = 64;
    localparam int WAIT_DEPTH   = 64;

    localparam int FS_IW = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
    localparam int FS_CW = $clog2(FREE_SLOTS + 1);
    localparam int AC_IW = (ACTIVE_SLOTS > 1) ? $clog2(ACTIVE_SLOTS) : 1;
    localparam int WQ_IW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int WQ_CW = $clog2(WAIT_DEPTH + 1);

    localparam logic [31:0] RESET_TOTAL = 32'd65536;

    typedef struct packed {
        logic        drain;
        logic [31:0] t;
        logic [31:0] m;
        logic [31:0] p;
    } req_t;

    typedef struct packed {
        logic        ovf;
        logic [31:0] finish;
        logic [31:0] waited;
        logic [31:0] start;
        logic        placed;
    } res_t;

    typedef struct packed {
        logic req_ready;
        logic cfg_ready;
    } stat_t;

endpackage

FILE: design/ffta_core.sv
// Allocation sequencer with free span, active and wait tables.
module ffta_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  ffta_pkg::req_t    req,
    input  logic              cfg_we,
    input  logic [31:0]       cfg_data,
    input  logic              res_free,
    output logic              done,
    output ffta_pkg::res_t    res,
    output ffta_pkg::stat_t   stat
);

    localparam int FS_IW = ffta_pkg::FS_IW;
    localparam int FS_CW = ffta_pkg::FS_CW;
    localparam int AC_IW = ffta_pkg::AC_IW;
    localparam int WQ_IW = ffta_pkg::WQ_IW;
    localparam int WQ_CW = ffta_pkg::WQ_CW;
    localparam int SW    = WQ_CW + 1;

    typedef enum logic [27:0] {
        S_IDLE       = 28'h0000001,
        S_MIN_RD     = 28'h0000002,
        S_MIN_EV     = 28'h0000004,
        S_MIN_DONE   = 28'h0000008,
        S_GRP_RD     = 28'h0000010,
        S_GRP_EV     = 28'h0000020,
        S_GRP_NEXT   = 28'h0000040,
        S_GRP_END    = 28'h0000080,
        S_RETRY      = 28'h0000100,
        S_RETRY_RD   = 28'h0000200,
        S_PL_START   = 28'h0000400,
        S_PL_RD      = 28'h0000800,
        S_PL_EV      = 28'h0001000,
        S_PL_SLOT    = 28'h0002000,
        S_PL_WRITE   = 28'h0004000,
        S_PL_DONE    = 28'h0008000,
        S_REL_START  = 28'h0010000,
        S_REL_RD     = 28'h0020000,
        S_REL_EV     = 28'h0040000,
        S_REL_DECIDE = 28'h0080000,
        S_INS_RD     = 28'h0100000,
        S_INS_WR     = 28'h0200000,
        S_INS_FIN    = 28'h0400000,
        S_DEL_CHK    = 28'h0800000,
        S_DEL_RD     = 28'h1000000,
        S_DEL_WR     = 28'h2000000,
        S_REQ_END    = 28'h4000000,
        S_OUT        = 28'h8000000
    } state_t;

    typedef struct packed {
        logic [31:0] lo;
        logic [31:0] hi;
    } span_t;

    typedef struct packed {
        logic [31:0] t;
        logic [31:0] lo;
        logic [31:0] hi;
    } alloc_t;

    typedef struct packed {
        logic [31:0] m;
        logic [31:0] p;
    } wentry_t;

    // memories
    span_t   fs_mem [ffta_pkg::FREE_SLOTS];
    alloc_t  ac_mem [ffta_pkg::ACTIVE_SLOTS];
    wentry_t wq_mem [ffta_pkg::WAIT_DEPTH];

    span_t   fs_rd_reg;
    alloc_t  ac_rd_reg;
    wentry_t wq_rd_reg;

    state_t                        state_reg;
    ffta_pkg::req_t                req_reg;
    logic [31:0]                   tm_reg;
    logic                          init_pending_reg;
    logic [ffta_pkg::ACTIVE_SLOTS-1:0] valid_reg;
    logic [AC_IW-1:0]              idx_reg;
    logic [AC_IW-1:0]              aidx_reg;
    logic [FS_CW-1:0]              k_reg;
    logic [FS_CW-1:0]              fs_count_reg;
    logic [FS_CW-1:0]              rel_i_reg;
    logic [FS_CW-1:0]              sp_idx_reg;
    logic [31:0]                   min_reg;
    logic                          any_reg;
    logic [31:0]                   cur_reg;
    logic [31:0]                   rel_lo_reg;
    logic [31:0]                   rel_hi_reg;
    span_t                         prev_reg;
    span_t                         cspan_reg;
    logic [31:0]                   pt_reg;
    logic [31:0]                   pm_reg;
    logic [31:0]                   pp_reg;
    logic [31:0]                   sp_lo_reg;
    logic [31:0]                   sp_hi_reg;
    logic                          ret_retry_reg;
    logic                          del_rel_reg;
    logic                          pl_ok_reg;
    logic [WQ_IW-1:0]              wq_head_reg;
    logic [WQ_CW-1:0]              wq_count_reg;
    logic [31:0]                   wait_total_reg;
    logic [31:0]                   last_time_reg;
    logic                          released_reg;
    logic                          ovf_reg;
    logic [31:0]                   addr_reg;
    logic                          placed_reg;

    logic [FS_CW-1:0] k_p1;
    logic [FS_CW-1:0] k_m1;
    logic [FS_IW-1:0] fs_raddr;
    logic             fs_we;
    logic [FS_IW-1:0] fs_waddr;
    span_t            fs_wdata;
    logic             ac_we;
    alloc_t           ac_wdata;
    logic             wq_we;
    logic [WQ_IW-1:0] wq_waddr;
    logic [31:0]      pl_end;
    logic [32:0]      et_sum;
    logic [31:0]      et;
    logic [31:0]      span_len;
    logic             ac_last;
    logic             aidx_last;
    logic             left_m;
    logic             right_m;
    logic [SW-1:0]    slot_sum;
    logic [SW-1:0]    slot_w;
    logic [WQ_IW-1:0] head_next;

    assign k_p1     = k_reg + 1'b1;
    assign k_m1     = k_reg - 1'b1;
    assign pl_end   = sp_lo_reg + pm_reg;
    assign et_sum   = {1'b0, pt_reg} + {1'b0, pp_reg};
    assign et       = et_sum[32] ? 32'hFFFF_FFFF : et_sum[31:0];
    assign span_len = fs_rd_reg.hi - fs_rd_reg.lo;
    assign ac_last  = (idx_reg == AC_IW'(ffta_pkg::ACTIVE_SLOTS - 1));
    assign aidx_last = (aidx_reg == AC_IW'(ffta_pkg::ACTIVE_SLOTS - 1));
    assign left_m   = (rel_i_reg != '0) && (prev_reg.hi == rel_lo_reg);
    assign right_m  = (rel_i_reg < fs_count_reg) && (cspan_reg.lo == rel_hi_reg);
    assign slot_sum = SW'(wq_head_reg) + SW'(wq_count_reg);
    assign slot_w   = (slot_sum >= SW'(ffta_pkg::WAIT_DEPTH)) ?
                      slot_sum - SW'(ffta_pkg::WAIT_DEPTH) : slot_sum;
    assign wq_waddr = slot_w[WQ_IW-1:0];
    assign head_next = (wq_head_reg == WQ_IW'(ffta_pkg::WAIT_DEPTH - 1)) ?
                       '0 : wq_head_reg + 1'b1;

    always_comb
    begin
        case (state_reg)
            S_INS_RD: fs_raddr = k_m1[FS_IW-1:0];
            S_DEL_RD: fs_raddr = k_p1[FS_IW-1:0];
            default:  fs_raddr = k_reg[FS_IW-1:0];
        endcase
    end

    always_comb
    begin
        fs_we    = 1'b0;
        fs_waddr = k_reg[FS_IW-1:0];
        fs_wdata = fs_rd_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (init_pending_reg)
                begin
                    fs_we    = 1'b1;
                    fs_waddr = '0;
                    fs_wdata = '{lo: 32'd0, hi: tm_reg};
                end
            end
            S_PL_WRITE:
            begin
                if (pl_end != sp_hi_reg)
                begin
                    fs_we    = 1'b1;
                    fs_waddr = sp_idx_reg[FS_IW-1:0];
                    fs_wdata = '{lo: pl_end, hi: sp_hi_reg};
                end
            end
            S_REL_DECIDE:
            begin
                if (left_m && right_m)
                begin
                    fs_we    = 1'b1;
                    fs_waddr = FS_IW'(rel_i_reg - 1'b1);
                    fs_wdata = '{lo: prev_reg.lo, hi: cspan_reg.hi};
                end
                else if (left_m)
                begin
                    fs_we    = 1'b1;
                    fs_waddr = FS_IW'(rel_i_reg - 1'b1);
                    fs_wdata = '{lo: prev_reg.lo, hi: rel_hi_reg};
                end
                else if (right_m)
                begin
                    fs_we    = 1'b1;
                    fs_waddr = rel_i_reg[FS_IW-1:0];
                    fs_wdata = '{lo: rel_lo_reg, hi: cspan_reg.hi};
                end
                else if (fs_count_reg < FS_CW'(ffta_pkg::FREE_SLOTS) &&
                         fs_count_reg == rel_i_reg)
                begin
                    fs_we    = 1'b1;
                    fs_waddr = rel_i_reg[FS_IW-1:0];
                    fs_wdata = '{lo: rel_lo_reg, hi: rel_hi_reg};
                end
            end
            S_INS_WR:
            begin
                fs_we = 1'b1;
            end
            S_INS_FIN:
            begin
                fs_we    = 1'b1;
                fs_waddr = rel_i_reg[FS_IW-1:0];
                fs_wdata = '{lo: rel_lo_reg, hi: rel_hi_reg};
            end
            S_DEL_WR:
            begin
                fs_we = 1'b1;
            end
            default:
            begin
                fs_we = 1'b0;
            end
        endcase
    end

    assign ac_we    = (state_reg == S_PL_WRITE);
    assign ac_wdata = '{t: et, lo: sp_lo_reg, hi: pl_end};
    assign wq_we    = (state_reg == S_REQ_END) && !placed_reg &&
                      (wq_count_reg < WQ_CW'(ffta_pkg::WAIT_DEPTH));

    always_ff @(posedge clk)
    begin
        if (fs_we)
            fs_mem[fs_waddr] <= fs_wdata;
        fs_rd_reg <= fs_mem[fs_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ac_we)
            ac_mem[aidx_reg] <= ac_wdata;
        ac_rd_reg <= ac_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (wq_we)
            wq_mem[wq_waddr] <= '{m: req_reg.m, p: req_reg.p};
        wq_rd_reg <= wq_mem[wq_head_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            req_reg          <= '0;
            tm_reg           <= ffta_pkg::RESET_TOTAL;
            init_pending_reg <= 1'b1;
            valid_reg        <= '0;
            idx_reg          <= '0;
            aidx_reg         <= '0;
            k_reg            <= '0;
            fs_count_reg     <= '0;
            rel_i_reg        <= '0;
            sp_idx_reg       <= '0;
            min_reg          <= '0;
            any_reg          <= 1'b0;
            cur_reg          <= '0;
            rel_lo_reg       <= '0;
            rel_hi_reg       <= '0;
            prev_reg         <= '0;
            cspan_reg        <= '0;
            pt_reg           <= '0;
            pm_reg           <= '0;
            pp_reg           <= '0;
            sp_lo_reg        <= '0;
            sp_hi_reg        <= '0;
            ret_retry_reg    <= 1'b0;
            del_rel_reg      <= 1'b0;
            pl_ok_reg        <= 1'b0;
            wq_head_reg      <= '0;
            wq_count_reg     <= '0;
            wait_total_reg   <= '0;
            last_time_reg    <= '0;
            released_reg     <= 1'b0;
            ovf_reg          <= 1'b0;
            addr_reg         <= '0;
            placed_reg       <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (init_pending_reg)
                    begin
                        fs_count_reg     <= (tm_reg != 32'd0) ? FS_CW'(1) : '0;
                        init_pending_reg <= 1'b0;
                    end
                    else if (start)
                    begin
                        req_reg      <= req;
                        ovf_reg      <= 1'b0;
                        placed_reg   <= 1'b0;
                        addr_reg     <= '0;
                        released_reg <= 1'b0;
                        idx_reg      <= '0;
                        any_reg      <= 1'b0;
                        state_reg    <= S_MIN_RD;
                    end
                end
                S_MIN_RD:
                begin
                    state_reg <= S_MIN_EV;
                end
                S_MIN_EV:
                begin
                    if (valid_reg[idx_reg] && (!any_reg || ac_rd_reg.t < min_reg))
                    begin
                        min_reg <= ac_rd_reg.t;
                        any_reg <= 1'b1;
                    end
                    if (ac_last)
                        state_reg <= S_MIN_DONE;
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_MIN_RD;
                    end
                end
                S_MIN_DONE:
                begin
                    if (any_reg && (req_reg.drain || min_reg <= req_reg.t))
                    begin
                        cur_reg   <= min_reg;
                        idx_reg   <= '0;
                        state_reg <= S_GRP_RD;
                    end
                    else if (req_reg.drain)
                        state_reg <= S_OUT;
                    else
                    begin
                        pt_reg        <= req_reg.t;
                        pm_reg        <= req_reg.m;
                        pp_reg        <= req_reg.p;
                        ret_retry_reg <= 1'b0;
                        state_reg     <= S_PL_START;
                    end
                end
                S_GRP_RD:
                begin
                    state_reg <= S_GRP_EV;
                end
                S_GRP_EV:
                begin
                    if (valid_reg[idx_reg] && ac_rd_reg.t == cur_reg)
                    begin
                        valid_reg[idx_reg] <= 1'b0;
                        rel_lo_reg         <= ac_rd_reg.lo;
                        rel_hi_reg         <= ac_rd_reg.hi;
                        state_reg          <= S_REL_START;
                    end
                    else
                        state_reg <= S_GRP_NEXT;
                end
                S_GRP_NEXT:
                begin
                    if (ac_last)
                        state_reg <= S_GRP_END;
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_GRP_RD;
                    end
                end
                S_GRP_END:
                begin
                    last_time_reg <= cur_reg;
                    released_reg  <= 1'b1;
                    state_reg     <= S_RETRY;
                end
                S_RETRY:
                begin
                    if (wq_count_reg == '0)
                    begin
                        idx_reg   <= '0;
                        any_reg   <= 1'b0;
                        state_reg <= S_MIN_RD;
                    end
                    else
                        state_reg <= S_RETRY_RD;
                end
                S_RETRY_RD:
                begin
                    pt_reg        <= cur_reg;
                    pm_reg        <= wq_rd_reg.m;
                    pp_reg        <= wq_rd_reg.p;
                    ret_retry_reg <= 1'b1;
                    state_reg     <= S_PL_START;
                end
                S_PL_START:
                begin
                    k_reg <= '0;
                    if (fs_count_reg == '0)
                    begin
                        pl_ok_reg <= 1'b0;
                        state_reg <= S_PL_DONE;
                    end
                    else
                        state_reg <= S_PL_RD;
                end
                S_PL_RD:
                begin
                    state_reg <= S_PL_EV;
                end
                S_PL_EV:
                begin
                    if (span_len >= pm_reg)
                    begin
                        sp_lo_reg  <= fs_rd_reg.lo;
                        sp_hi_reg  <= fs_rd_reg.hi;
                        sp_idx_reg <= k_reg;
                        aidx_reg   <= '0;
                        state_reg  <= S_PL_SLOT;
                    end
                    else if (k_p1 == fs_count_reg)
                    begin
                        pl_ok_reg <= 1'b0;
                        state_reg <= S_PL_DONE;
                    end
                    else
                    begin
                        k_reg     <= k_p1;
                        state_reg <= S_PL_RD;
                    end
                end
                S_PL_SLOT:
                begin
                    if (!valid_reg[aidx_reg])
                        state_reg <= S_PL_WRITE;
                    else if (aidx_last)
                    begin
                        ovf_reg   <= 1'b1;
                        pl_ok_reg <= 1'b0;
                        state_reg <= S_PL_DONE;
                    end
                    else
                        aidx_reg <= aidx_reg + 1'b1;
                end
                S_PL_WRITE:
                begin
                    valid_reg[aidx_reg] <= 1'b1;
                    addr_reg            <= sp_lo_reg;
                    pl_ok_reg           <= 1'b1;
                    if (pl_end == sp_hi_reg)
                    begin
                        k_reg       <= sp_idx_reg;
                        del_rel_reg <= 1'b0;
                        state_reg   <= S_DEL_CHK;
                    end
                    else
                        state_reg <= S_PL_DONE;
                end
                S_PL_DONE:
                begin
                    if (ret_retry_reg)
                    begin
                        if (pl_ok_reg)
                        begin
                            wq_head_reg  <= head_next;
                            wq_count_reg <= wq_count_reg - 1'b1;
                            state_reg    <= S_RETRY;
                        end
                        else
                        begin
                            idx_reg   <= '0;
                            any_reg   <= 1'b0;
                            state_reg <= S_MIN_RD;
                        end
                    end
                    else
                    begin
                        placed_reg <= pl_ok_reg;
                        state_reg  <= S_REQ_END;
                    end
                end
                S_REQ_END:
                begin
                    if (!placed_reg)
                    begin
                        addr_reg       <= '0;
                        wait_total_reg <= wait_total_reg + 1'b1;
                        if (wq_count_reg < WQ_CW'(ffta_pkg::WAIT_DEPTH))
                            wq_count_reg <= wq_count_reg + 1'b1;
                        else
                            ovf_reg <= 1'b1;
                    end
                    state_reg <= S_OUT;
                end
                S_REL_START:
                begin
                    k_reg <= '0;
                    if (rel_lo_reg >= rel_hi_reg)
                        state_reg <= S_GRP_NEXT;
                    else if (fs_count_reg == '0)
                    begin
                        rel_i_reg <= '0;
                        state_reg <= S_REL_DECIDE;
                    end
                    else
                        state_reg <= S_REL_RD;
                end
                S_REL_RD:
                begin
                    state_reg <= S_REL_EV;
                end
                S_REL_EV:
                begin
                    if (fs_rd_reg.lo <= rel_lo_reg)
                    begin
                        prev_reg <= fs_rd_reg;
                        if (k_p1 == fs_count_reg)
                        begin
                            rel_i_reg <= k_p1;
                            state_reg <= S_REL_DECIDE;
                        end
                        else
                        begin
                            k_reg     <= k_p1;
                            state_reg <= S_REL_RD;
                        end
                    end
                    else
                    begin
                        cspan_reg <= fs_rd_reg;
                        rel_i_reg <= k_reg;
                        state_reg <= S_REL_DECIDE;
                    end
                end
                S_REL_DECIDE:
                begin
                    if (left_m && right_m)
                    begin
                        k_reg       <= rel_i_reg;
                        del_rel_reg <= 1'b1;
                        state_reg   <= S_DEL_CHK;
                    end
                    else if (left_m || right_m)
                        state_reg <= S_GRP_NEXT;
                    else if (fs_count_reg < FS_CW'(ffta_pkg::FREE_SLOTS))
                    begin
                        if (fs_count_reg == rel_i_reg)
                        begin
                            fs_count_reg <= fs_count_reg + 1'b1;
                            state_reg    <= S_GRP_NEXT;
                        end
                        else
                        begin
                            k_reg     <= fs_count_reg;
                            state_reg <= S_INS_RD;
                        end
                    end
                    else
                    begin
                        // no slot for an isolated span: units are lost
                        ovf_reg   <= 1'b1;
                        state_reg <= S_GRP_NEXT;
                    end
                end
                S_INS_RD:
                begin
                    state_reg <= S_INS_WR;
                end
                S_INS_WR:
                begin
                    k_reg <= k_m1;
                    if (k_m1 == rel_i_reg)
                        state_reg <= S_INS_FIN;
                    else
                        state_reg <= S_INS_RD;
                end
                S_INS_FIN:
                begin
                    fs_count_reg <= fs_count_reg + 1'b1;
                    state_reg    <= S_GRP_NEXT;
                end
                S_DEL_CHK:
                begin
                    if (k_p1 >= fs_count_reg)
                    begin
                        fs_count_reg <= fs_count_reg - 1'b1;
                        state_reg    <= del_rel_reg ? S_GRP_NEXT : S_PL_DONE;
                    end
                    else
                        state_reg <= S_DEL_RD;
                end
                S_DEL_RD:
                begin
                    state_reg <= S_DEL_WR;
                end
                S_DEL_WR:
                begin
                    k_reg     <= k_p1;
                    state_reg <= S_DEL_CHK;
                end
                S_OUT:
                begin
                    if (res_free)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            // register write re-initializes the region; only taken while idle
            if (cfg_we)
            begin
                tm_reg           <= cfg_data;
                init_pending_reg <= 1'b1;
                valid_reg        <= '0;
                wq_head_reg      <= '0;
                wq_count_reg     <= '0;
                wait_total_reg   <= '0;
                last_time_reg    <= '0;
            end
        end
    end

    assign done           = (state_reg == S_OUT) && res_free;
    assign res.placed     = placed_reg;
    assign res.start      = placed_reg ? addr_reg : 32'd0;
    assign res.waited     = wait_total_reg;
    assign res.finish     = (req_reg.drain && released_reg) ? last_time_reg : 32'd0;
    assign res.ovf        = ovf_reg;
    assign stat.req_ready = (state_reg == S_IDLE) && !init_pending_reg;
    assign stat.cfg_ready = (state_reg == S_IDLE) && !init_pending_reg;

endmodule

FILE: design/first_fit_timed_allocator.sv
// First-fit timed allocator: stream ports, result register and config channel.
// Requests are handled one at a time: a pass that finds the earliest end time
// reads every active slot, each release group rescans the active table, each
// release walks and shifts the free span table, and a placement walks free
// spans and active slots. A non-drain request with nothing to release runs the
// earliest end time pass and then the placement walk. All table accesses go
// through memories with separate read and write addresses and registered
// reads. After reset or a total_memory write the block loads the initial free
// span before s_tready rises. A config write offered in the same cycle as a
// request goes first.
module first_fit_timed_allocator (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [95:0]   s_tdata,   // arrival_time, request_size, hold_duration
    input  logic          s_tuser,   // mode
    output logic          m_tvalid,
    input  logic          m_tready,
    // placed_now, start_address, waited_count, finish_time, table_overflow, pad
    output logic [103:0]  m_tdata,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [31:0]   cfg_data   // total_memory
);

    ffta_pkg::req_t  req;
    ffta_pkg::res_t  res;
    ffta_pkg::stat_t stat;
    logic            start;
    logic            done;
    logic            res_free;
    logic            cfg_we;
    logic            out_valid_reg;
    ffta_pkg::res_t  out_res_reg;

    assign req.drain = s_tuser;
    assign req.t     = s_tdata[31:0];
    assign req.m     = s_tdata[63:32];
    assign req.p     = s_tdata[95:64];

    assign s_tready  = stat.req_ready && !cfg_valid;
    assign cfg_ready = stat.cfg_ready;
    assign start     = s_tvalid && s_tready;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign res_free  = !out_valid_reg || m_tready;

    ffta_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req      (req),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .res_free (res_free),
        .done     (done),
        .res      (res),
        .stat     (stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (done)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (done)
            out_res_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_res_reg};

`ifndef SYNTH
    // a request transaction keeps the block busy for at least the next cycle
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("s_tready high right after a request transaction");

    // a config write forces the initial span load before new requests
    a_init_after_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready) |=> !s_tready)
        else $error("request accepted before region init");

    // a placed request never reports a drain finish time
    a_placed_no_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[0]) |-> (m_tdata[96:65] == 32'd0))
        else $error("placed result carries a finish time");
`endif

endmodule
